// ===== rtl/rv32dec_pkg.sv =====
// rv32dec_pkg: opcodes, format codes and the decoded result type for the
// RV32I instruction field decoder. No dependencies.
package rv32dec_pkg;

   // Major opcodes (instruction bits 6..0)
   localparam logic [6:0] OPC_R      = 7'h33;
   localparam logic [6:0] OPC_IARITH = 7'h13;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;

   // funct7 values
   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   // funct3 values with special meaning
   localparam logic [2:0] F3_ADD_SUB = 3'd0;
   localparam logic [2:0] F3_SLL     = 3'd1;
   localparam logic [2:0] F3_SR      = 3'd5;
   localparam logic [2:0] F3_LW      = 3'd2;
   localparam logic [2:0] F3_LD      = 3'd3;
   localparam logic [2:0] F3_BLT_LO  = 3'd2;
   localparam logic [2:0] F3_BLT_HI  = 3'd3;
   localparam logic [2:0] F3_LWU     = 3'd6;
   localparam logic [2:0] F3_LDU     = 3'd7;
   localparam logic [2:0] F3_JALR    = 3'd0;

   localparam int unsigned IMM_W = 21;

   // Instruction format codes
   typedef enum logic [2:0] {
      FMT_R      = 3'd0,
      FMT_IARITH = 3'd1,
      FMT_LOAD   = 3'd2,
      FMT_STORE  = 3'd3,
      FMT_BRANCH = 3'd4,
      FMT_JAL    = 3'd5,
      FMT_JALR   = 3'd6
   } fmt_type;

   // One decoded word
   typedef struct packed {
      logic             legal;
      fmt_type          fmt;
      logic [3:0]       mnemonic_code;
      logic [4:0]       dest_reg;
      logic [4:0]       src1_reg;
      logic [4:0]       src2_reg;
      logic [IMM_W-1:0] immediate;
   } dec_result_type;

endpackage

// ===== rtl/rv32i_instruction_field_decoder_core.sv =====
// rv32i_instruction_field_decoder_core: top level of the RV32I field decoder.
// Depends on rv32dec_pkg for opcodes, format codes and the result struct.
//
// Usage:
//   Input channel req_valid/req_ready carries one 32-bit instruction word
//   (req_instr_word). Output channel rsp_valid/rsp_ready carries the decoded
//   fields: legal, format, mnemonic code {bit 30 (R, shifts) or 0, funct3},
//   rd, rs1, rs2 and the raw (not sign extended) immediate, with branch and
//   jal offsets already shifted left by one. Illegal words give all fields zero.
// Timing:
//   Two register stages: an input register, then the decode logic, then a
//   result register. A word accepted into the input register moves, decoded,
//   into the result register, which drives rsp_, once it is empty or taken.
//   One word is accepted per cycle, sustained, while the receiver takes
//   results; throughput is set by the two-entry pipeline.
// Stall and reset:
//   When rsp_ready is low the result holds; the input register still fills,
//   so one more word is accepted before req_ready drops. A synchronous,
//   active-high reset empties both stages; no other state exists.
module rv32i_instruction_field_decoder_core
   import rv32dec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instr_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_legal,
   output logic [2:0]  rsp_format,
   output logic [3:0]  rsp_mnemonic_code,
   output logic [4:0]  rsp_dest_reg,
   output logic [4:0]  rsp_src1_reg,
   output logic [4:0]  rsp_src2_reg,
   output logic [20:0] rsp_immediate
);

   logic           s1_valid_ff, s1_valid_in;
   logic [31:0]    s1_word_ff, s1_word_in;
   logic           s2_valid_ff, s2_valid_in;
   dec_result_type s2_result_ff, s2_result_in;
   dec_result_type dec;
   logic           s1_advance;

   // Pipeline flow control
   assign s1_advance = !s2_valid_ff || rsp_ready;
   assign req_ready  = !s1_valid_ff || s1_advance;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_word_in   = s1_word_ff;
      s2_valid_in  = s2_valid_ff;
      s2_result_in = s2_result_ff;
      if (s1_advance) begin
         s2_valid_in  = s1_valid_ff;
         s2_result_in = dec;
         s1_valid_in  = 1'b0;
      end
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
         s1_word_in  = req_instr_word;
      end
   end

   // Field decode of the registered word
   always_comb begin
      logic [6:0] opc;
      logic [2:0] f3;
      logic [6:0] f7;
      logic       ok;
      opc = s1_word_ff[6:0];
      f3  = s1_word_ff[14:12];
      f7  = s1_word_ff[31:25];
      ok  = 1'b0;
      dec = '0;
      case (opc)
         OPC_R: begin
            ok = (f7 == F7_BASE) ||
                 (f7 == F7_ALT && (f3 == F3_ADD_SUB || f3 == F3_SR));
            dec.fmt           = FMT_R;
            dec.mnemonic_code = {s1_word_ff[30], f3};
            dec.dest_reg      = s1_word_ff[11:7];
            dec.src1_reg      = s1_word_ff[19:15];
            dec.src2_reg      = s1_word_ff[24:20];
         end
         OPC_IARITH: begin
            dec.fmt      = FMT_IARITH;
            dec.dest_reg = s1_word_ff[11:7];
            dec.src1_reg = s1_word_ff[19:15];
            if (f3 == F3_SLL || f3 == F3_SR) begin
               // shift immediates: 5-bit shamt, bit 30 picks sra
               ok = (f7 == F7_BASE) || (f3 == F3_SR && f7 == F7_ALT);
               dec.mnemonic_code = {s1_word_ff[30], f3};
               dec.immediate     = {16'd0, s1_word_ff[24:20]};
            end else begin
               ok = 1'b1;
               dec.mnemonic_code = {1'b0, f3};
               dec.immediate     = {9'd0, s1_word_ff[31:20]};
            end
         end
         OPC_LOAD: begin
            ok = !(f3 == F3_LD || f3 == F3_LWU || f3 == F3_LDU);
            dec.fmt           = FMT_LOAD;
            dec.mnemonic_code = {1'b0, f3};
            dec.dest_reg      = s1_word_ff[11:7];
            dec.src1_reg      = s1_word_ff[19:15];
            dec.immediate     = {9'd0, s1_word_ff[31:20]};
         end
         OPC_STORE: begin
            ok = (f3 <= F3_LW);
            dec.fmt           = FMT_STORE;
            dec.mnemonic_code = {1'b0, f3};
            dec.src1_reg      = s1_word_ff[19:15];
            dec.src2_reg      = s1_word_ff[24:20];
            dec.immediate     = {9'd0, s1_word_ff[31:25], s1_word_ff[11:7]};
         end
         OPC_BRANCH: begin
            ok = !(f3 == F3_BLT_LO || f3 == F3_BLT_HI);
            dec.fmt           = FMT_BRANCH;
            dec.mnemonic_code = {1'b0, f3};
            dec.src1_reg      = s1_word_ff[19:15];
            dec.src2_reg      = s1_word_ff[24:20];
            dec.immediate     = {8'd0, s1_word_ff[31], s1_word_ff[7],
                                 s1_word_ff[30:25], s1_word_ff[11:8], 1'b0};
         end
         OPC_JAL: begin
            ok = 1'b1;
            dec.fmt       = FMT_JAL;
            dec.dest_reg  = s1_word_ff[11:7];
            dec.immediate = {s1_word_ff[31], s1_word_ff[19:12], s1_word_ff[20],
                             s1_word_ff[30:21], 1'b0};
         end
         OPC_JALR: begin
            ok = (f3 == F3_JALR);
            dec.fmt           = FMT_JALR;
            dec.mnemonic_code = {1'b0, f3};
            dec.dest_reg      = s1_word_ff[11:7];
            dec.src1_reg      = s1_word_ff[19:15];
            dec.immediate     = {9'd0, s1_word_ff[31:20]};
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      // illegal words report all fields zero
      if (!ok) begin
         dec = '0;
      end
      dec.legal = ok;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_word_ff   <= s1_word_in;
      s2_result_ff <= s2_result_in;
   end

   assign rsp_valid         = s2_valid_ff;
   assign rsp_legal         = s2_result_ff.legal;
   assign rsp_format        = s2_result_ff.fmt;
   assign rsp_mnemonic_code = s2_result_ff.mnemonic_code;
   assign rsp_dest_reg      = s2_result_ff.dest_reg;
   assign rsp_src1_reg      = s2_result_ff.src1_reg;
   assign rsp_src2_reg      = s2_result_ff.src2_reg;
   assign rsp_immediate     = s2_result_ff.immediate;

endmodule
